### src/ilie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilie_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  // index and count fields are fixed at five bits
  localparam int CNT_W       = 5;
  localparam int STAT_W      = 2;
  localparam int REQ_W       = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_PUSH   = 3'd2,
    REQ_POP    = 3'd3,
    REQ_INSERT = 3'd4,
    REQ_ERASE  = 3'd5,
    REQ_RESIZE = 3'd6,
    REQ_CLEAR  = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // work the back end has to do on the cell store
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_UP    = 3'd3,
    OP_DOWN  = 3'd4,
    OP_FILL  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [CNT_W-1:0]      idx;
    logic [CNT_W-1:0]      old_cnt;
    logic [CNT_W-1:0]      new_cnt;
    logic [DATA_WIDTH-1:0] value;
    status_t               status;
  } cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      item_count;
    status_t               status;
  } res_t;

endpackage

`default_nettype wire

### src/ilie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ilie_front
  import ilie_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [REQ_W-1:0]      in_req,
  input  wire logic [CNT_W-1:0]      in_index,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             idx_live;
  logic             at_cap;
  cmd_t             cmd;

  assign idx_live = in_index < count_r;
  assign at_cap   = count_r >= CNT_W'(CAPACITY);

  // classify: status and new count depend only on the request, index and count, not on cell data
  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.idx     = in_index;
    cmd.old_cnt = count_r;
    cmd.new_cnt = count_r;
    cmd.value   = in_value;
    cmd.status  = ST_OK;
    unique case (req_t'(in_req))
      REQ_READ: begin
        if (idx_live) cmd.op = OP_READ;
        else cmd.status = ST_RANGE;
      end
      REQ_WRITE: begin
        if (idx_live) cmd.op = OP_WRITE;
        else cmd.status = ST_RANGE;
      end
      REQ_PUSH: begin
        if (at_cap) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op      = OP_WRITE;
          cmd.idx     = count_r;
          cmd.new_cnt = count_r + 1'b1;
        end
      end
      REQ_POP: begin
        if (count_r == '0) cmd.status = ST_EMPTY;
        else cmd.new_cnt = count_r - 1'b1;
      end
      REQ_INSERT: begin
        if (!idx_live) begin
          cmd.status = ST_RANGE;
        end else if (at_cap) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op      = OP_UP;
          cmd.new_cnt = count_r + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (!idx_live) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.op      = OP_DOWN;
          cmd.new_cnt = count_r - 1'b1;
        end
      end
      REQ_RESIZE: begin
        if (in_index > CNT_W'(CAPACITY)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.new_cnt = in_index;
          if (in_index > count_r) cmd.op = OP_FILL;
        end
      end
      REQ_CLEAR: cmd.new_cnt = '0;
      default: cmd.status = ST_OK;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_cmd    = cmd;

  assign count_nxt = q_push ? cmd.new_cnt : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ilie_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ilie_queue
  import ilie_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full      = fill_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = fill_r != '0;
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) fill_nxt = fill_r + 1'b1;
    else if (do_pop && !do_push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

### src/ilie_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ilie_back
  import ilie_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_UP   = 6'b000100,
    S_DOWN = 6'b001000,
    S_FILL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  wpend_r, wpend_nxt;
  logic [ADDR_W-1:0]     waddr_r, waddr_nxt;
  logic [DATA_WIDTH-1:0] rdata_r, rdata_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_r, out_nxt;

  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [CNT_W-1:0]      ptr_dec, ptr_inc;

  assign ptr_dec = ptr_r - 1'b1;
  assign ptr_inc = ptr_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    wpend_nxt     = wpend_r;
    waddr_nxt     = waddr_r;
    rdata_nxt     = rdata_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ptr_dec[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = waddr_r;
    wr_data       = mem_q_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          rdata_nxt = '0;
          wpend_nxt = 1'b0;
          case (q_cmd.op)
            OP_READ: begin
              rd_en     = 1'b1;
              rd_addr   = q_cmd.idx[ADDR_W-1:0];
              state_nxt = S_READ;
            end
            OP_WRITE: begin
              wr_en     = 1'b1;
              wr_addr   = q_cmd.idx[ADDR_W-1:0];
              wr_data   = q_cmd.value;
              state_nxt = S_DONE;
            end
            OP_UP: begin
              ptr_nxt   = q_cmd.old_cnt;
              state_nxt = S_UP;
            end
            OP_DOWN: begin
              ptr_nxt   = q_cmd.idx + 1'b1;
              state_nxt = S_DOWN;
            end
            OP_FILL: begin
              ptr_nxt   = q_cmd.old_cnt;
              state_nxt = S_FILL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: begin
        rdata_nxt = mem_q_r;
        state_nxt = S_DONE;
      end
      // walk from the top down: read one below, write the previous read one up
      S_UP: begin
        wr_en = wpend_r;
        if (ptr_r > cmd_r.idx) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec[ADDR_W-1:0];
          waddr_nxt = ptr_r[ADDR_W-1:0];
          wpend_nxt = 1'b1;
          ptr_nxt   = ptr_dec;
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = cmd_r.idx[ADDR_W-1:0];
          wr_data   = cmd_r.value;
          state_nxt = S_DONE;
        end
      end
      // walk upward: read one above the gap, write it one down
      S_DOWN: begin
        wr_en = wpend_r;
        if (ptr_r < cmd_r.old_cnt) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r[ADDR_W-1:0];
          waddr_nxt = ptr_dec[ADDR_W-1:0];
          wpend_nxt = 1'b1;
          ptr_nxt   = ptr_inc;
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        if (ptr_r < cmd_r.new_cnt) begin
          wr_en   = 1'b1;
          wr_addr = ptr_r[ADDR_W-1:0];
          wr_data = cmd_r.value;
          ptr_nxt = ptr_inc;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.read_data  = rdata_r;
          out_nxt.item_count = cmd_r.new_cnt;
          out_nxt.status     = cmd_r.status;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    ptr_r   <= ptr_nxt;
    waddr_r <= waddr_nxt;
    rdata_r <= rdata_nxt;
    out_r   <= out_nxt;
  end

  // cell store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) cells[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= cells[rd_addr];
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

### src/indexed_list_insert_erase.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | valid/ready           | payload
// ---------+-----------+-----------------------+-----------------------------------------
// request  | in        | in_tvalid / in_tready | in_tuser req_type, in_tdata index, value
// result   | out       | out_tvalid/out_tready | out_tdata read_data, item_count, status
//
// one result word per request word; the front end classifies in the accept cycle
// read goes through S_READ to S_DONE; write, push, pop, resize shrink and clear go straight to S_DONE
// insert and erase walk the moved tail through the cell store (one write port, one read port),
// one element a cycle
// resize growth writes one new slot a cycle
// a two-word command queue keeps requests flowing while the back end is busy
// or while a finished result waits for out_tready
// reset: count goes to zero, cell contents stay undefined until written

module indexed_list_insert_erase
  import ilie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // index[4:0], value[36:5], zero pad
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // read_data[31:0], item_count[36:32], status[38:37], pad
);

  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t front_cmd, head_cmd;
  res_t res;

  // front end keeps its own count so classification never waits on the store
  ilie_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_tuser),
    .in_index (in_tdata[CNT_W-1:0]),
    .in_value (in_tdata[CNT_W +: DATA_WIDTH]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  ilie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  // back end owns the cell store and the result register
  ilie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res.status, res.item_count, res.read_data};

endmodule

`default_nettype wire

### src/ilie_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ilie_checker
  import ilie_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  logic [CNT_W-1:0]  cnt;
  logic [STAT_W-1:0] st;

  assign cnt = out_tdata[36:32];
  assign st  = out_tdata[38:37];

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= CNT_W'(CAPACITY))
    else $error("item count above capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> cnt == '0)
    else $error("empty status with live items");

  a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> out_tdata[31:0] == '0)
    else $error("refused request returned data");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench
  import ilie_pkg::*;
();

  localparam int RUN_WORDS   = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;   // longer than one full tail walk
  localparam int HOLD_CYCLES = 150;  // long receiver hold-off, fills the command queue

  // mirror of the list; predicts one result word per accepted request word
  class list_scoreboard;
    logic [DATA_WIDTH-1:0] cells [CAPACITY];
    int   live_count;
    res_t pending_results [$];
    int   failures;
    int   words_checked;
    int   req_seen [8];
    int   status_seen [4];
    int   peak_count;

    function new();
      live_count = 0;
      failures = 0;
      words_checked = 0;
      peak_count = 0;
      foreach (req_seen[k]) req_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function res_t apply_request(req_t req, logic [4:0] idx, logic [DATA_WIDTH-1:0] val);
      res_t r;
      int   i;
      r.read_data = '0;
      r.status = ST_OK;
      case (req)
        REQ_READ: begin
          if (idx < live_count) r.read_data = cells[idx[ADDR_W-1:0]];
          else r.status = ST_RANGE;
        end
        REQ_WRITE: begin
          if (idx < live_count) cells[idx[ADDR_W-1:0]] = val;
          else r.status = ST_RANGE;
        end
        REQ_PUSH: begin
          if (live_count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            cells[live_count[ADDR_W-1:0]] = val;
            live_count++;
          end
        end
        REQ_POP: begin
          if (live_count == 0) r.status = ST_EMPTY;
          else live_count--;
        end
        REQ_INSERT: begin
          // range is checked before full, so insert can never append
          if (idx >= live_count) begin
            r.status = ST_RANGE;
          end else if (live_count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = live_count; i > idx; i--)
              cells[i[ADDR_W-1:0]] = cells[ADDR_W'(i - 1)];
            cells[idx[ADDR_W-1:0]] = val;
            live_count++;
          end
        end
        REQ_ERASE: begin
          if (idx >= live_count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = idx; i + 1 < live_count; i++)
              cells[i[ADDR_W-1:0]] = cells[ADDR_W'(i + 1)];
            live_count--;
          end
        end
        REQ_RESIZE: begin
          // growth fills new slots, shrink only drops the count
          if (idx > CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = live_count; i < idx; i++) cells[i[ADDR_W-1:0]] = val;
            live_count = idx;
          end
        end
        default: live_count = 0;
      endcase
      r.item_count = live_count[CNT_W-1:0];
      return r;
    endfunction

    function void note_request(req_t req, logic [4:0] idx, logic [DATA_WIDTH-1:0] val);
      res_t r;
      r = apply_request(req, idx, val);
      pending_results = {pending_results, r};
      req_seen[req]++;
      status_seen[r.status]++;
      if (live_count > peak_count) peak_count = live_count;
    endfunction

    function void check_result(logic [39:0] word);
      res_t want;
      logic [31:0] got_data;
      logic [4:0]  got_count;
      logic [1:0]  got_status;
      got_data   = word[31:0];
      got_count  = word[36:32];
      got_status = word[38:37];
      words_checked++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word %h with nothing pending", word);
        return;
      end
      want = pending_results.pop_front();
      if (got_data !== want.read_data || got_count !== want.item_count ||
          got_status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("mismatch on word %0d: want data %h count %0d status %0d, got %h %0d %0d",
                   words_checked, want.read_data, want.item_count, want.status,
                   got_data, got_count, got_status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // index[4:0], value[36:5], zero pad
  logic [2:0]  in_tuser;    // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // read_data[31:0], item_count[36:32], status[38:37], pad

  list_scoreboard sb;
  int  cycle_count = 0;
  int  hold_off_cycles = 0;   // set by the sender, served by the receiver
  bit  sender_calm = 1'b0;    // no gaps between request words
  int  words_sent = 0;

  always #1 clk = ~clk;

  indexed_list_insert_erase dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // offer one request word after a random gap (none while the sender is calm), note it once it is taken
  task automatic send_request(req_t req, logic [4:0] idx, logic [31:0] val);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    // valid only drops when there is a real gap, never within the accept step
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, val, idx};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, idx, val);
    words_sent++;
  endtask

  // result side: random stalls, a calm stretch now and then, long hold-offs on request
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = ((taken / 37) % 3 == 2) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      taken++;
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, sb.pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : request_source
    int   n;
    int   pick;
    req_t req;
    logic [4:0]  idx;
    logic [31:0] val;

    sb = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_READ;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read, pop, write, insert and erase on an empty list are all refused
    send_request(REQ_READ,   5'd0, 32'h0000_0000);
    send_request(REQ_POP,    5'd0, 32'h0000_0000);
    send_request(REQ_WRITE,  5'd0, 32'h1234_5678);
    send_request(REQ_INSERT, 5'd0, 32'h1234_5678);
    send_request(REQ_ERASE,  5'd0, 32'h0000_0000);
    // data extremes
    send_request(REQ_PUSH,   5'd0, 32'h7fff_ffff);
    send_request(REQ_PUSH,   5'd31, 32'h8000_0000);
    send_request(REQ_PUSH,   5'd0, 32'h0000_0000);
    send_request(REQ_PUSH,   5'd0, 32'hffff_ffff);
    send_request(REQ_READ,   5'd3, 32'h0000_0000);
    send_request(REQ_READ,   5'd4, 32'h0000_0000);   // one past the end
    send_request(REQ_WRITE,  5'd1, 32'haaaa_aaaa);
    send_request(REQ_INSERT, 5'd0, 32'h5555_5555);
    send_request(REQ_INSERT, 5'd2, 32'hdead_beef);
    send_request(REQ_ERASE,  5'd5, 32'h0000_0000);   // last element
    send_request(REQ_ERASE,  5'd0, 32'h0000_0000);
    // fill to capacity, then everything that would grow is refused
    send_request(REQ_RESIZE, 5'd16, 32'h0f0f_0f0f);
    send_request(REQ_PUSH,   5'd0, 32'h1111_1111);
    send_request(REQ_INSERT, 5'd5, 32'h2222_2222);
    send_request(REQ_INSERT, 5'd16, 32'h2222_2222);  // range beats full
    send_request(REQ_RESIZE, 5'd17, 32'h3333_3333);
    send_request(REQ_RESIZE, 5'd31, 32'h3333_3333);
    send_request(REQ_READ,   5'd15, 32'h0000_0000);
    send_request(REQ_WRITE,  5'd31, 32'h4444_4444);
    send_request(REQ_ERASE,  5'd15, 32'h0000_0000);
    send_request(REQ_RESIZE, 5'd3, 32'h0000_0000);   // shrink
    send_request(REQ_CLEAR,  5'd9, 32'hffff_ffff);
    send_request(REQ_POP,    5'd0, 32'h0000_0000);

    // random: mostly valid positions so the list moves through all fill levels
    for (n = 0; n < RUN_WORDS; n++) begin
      sender_calm = ((n / 50) % 4 == 3);
      if (n == 200 || n == 500) hold_off_cycles = HOLD_CYCLES;

      pick = $urandom_range(0, 99);
      if (pick < 12)      req = REQ_READ;
      else if (pick < 24) req = REQ_WRITE;
      else if (pick < 42) req = REQ_PUSH;
      else if (pick < 52) req = REQ_POP;
      else if (pick < 67) req = REQ_INSERT;
      else if (pick < 80) req = REQ_ERASE;
      else if (pick < 88) req = REQ_RESIZE;
      else if (pick < 90) req = REQ_CLEAR;
      else                req = REQ_READ;

      // index: mostly inside the list, sometimes anywhere in the field
      if ($urandom_range(0, 99) < 15)
        idx = 5'($urandom_range(0, 31));
      else if (req == REQ_RESIZE)
        idx = 5'($urandom_range(0, CAPACITY));
      else if (sb.live_count > 0)
        idx = 5'($urandom_range(0, sb.live_count - 1));
      else
        idx = 5'd0;

      case ($urandom_range(0, 7))
        0:       val = 32'h7fff_ffff;
        1:       val = 32'h8000_0000;
        2:       val = 32'h0000_0000;
        3:       val = 32'hffff_ffff;
        default: val = $urandom;
      endcase

      send_request(req, idx, val);
    end

    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d request words, %0d results checked, peak fill %0d of %0d",
             words_sent, sb.words_checked, sb.peak_count, CAPACITY);
    $display("status ok %0d, empty %0d, out of range %0d, full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL]);
    if (sb.failures == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
src/ilie_pkg.sv
src/ilie_front.sv
src/ilie_queue.sv
src/ilie_back.sv
src/indexed_list_insert_erase.sv
src/ilie_checker.sv
tb/testbench.sv
